FILE: hdl/clc_pkg.sv
// shared types, codes and reset constants of the click latency calibrator
// no dependencies; imported by every module of the block
`default_nettype none

package clc_pkg;

    localparam int MEASURES_DEF     = 21;
    localparam int LATENCY_BITS_DEF = 20;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int FIELD_SAMPLE_W = 16;
    localparam int FIELD_LAT_W    = 20;
    localparam int PERIOD_W       = 14;
    localparam int THRESH_W       = 15;
    localparam int MIN_LAT_W      = 20;
    localparam int MARGIN_W       = 10;
    localparam int POS_W          = 13;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_INDEX_W    = 2;
    localparam int CMD_W          = 2;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(1024);
    localparam logic [THRESH_W-1:0]  THRESH_RESET  = THRESH_W'(26214);
    localparam logic [MIN_LAT_W-1:0] MIN_LAT_RESET = MIN_LAT_W'(512);
    localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = MARGIN_W'(50);
    localparam int                   LATENCY_RESET = 12000;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(2);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(8192);

    localparam logic [CMD_W-1:0] CMD_TICK  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_START = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_ABORT = CMD_W'(2);

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LAT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN  = CFG_INDEX_W'(3);

    typedef struct packed {
        logic [CMD_W-1:0]                 cmd;
        logic signed [FIELD_SAMPLE_W-1:0] mic_left;
        logic signed [FIELD_SAMPLE_W-1:0] mic_right;
    } clc_in_t;

    typedef struct packed {
        logic                   click_out;
        logic                   calibrating;
        logic                   click_detected;
        logic                   finished;
        logic [FIELD_LAT_W-1:0] latency_left;
        logic [FIELD_LAT_W-1:0] latency_right;
    } clc_out_t;

endpackage

`default_nettype wire

FILE: hdl/click_latency_calibrator.sv
// click latency calibrator: round-trip latency of a stereo audio path
//
// usage: one input word per audio sample tick or command (start, abort);
// every input word gives exactly one output word with the click drive,
// mode flag, detect and finish pulses and the current latencies
// config port: cfg_valid/cfg_index/cfg_data, always ready, write only while idle
// throughput: one input word per cycle while the output is not held and no search
// runs; the word is registered and shown on the output in the cycle after acceptance
// the word that completes the last measure starts the mode search over the
// measure store, which reads through the single read port of the store, one
// entry a cycle; no input is taken while the search runs
// output stall: a held output word holds off input once the register is full
// reset: normal mode, no run in progress, both latencies 12000,
// registers at their reset values; the measure store is not cleared
// depends on clc_pkg, clc_measure_mem, clc_mode_search
`default_nettype none

module click_latency_calibrator
    import clc_pkg::*;
#(
    parameter int MEASURES     = MEASURES_DEF,
    parameter int LATENCY_BITS = LATENCY_BITS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire clc_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output clc_out_t                    out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W   = (MEASURES > 1) ? $clog2(MEASURES) : 1;
    localparam int CNT_W   = $clog2(MEASURES + 1);
    localparam int SUM_W   = LATENCY_BITS + 1;
    localparam int CMP_W   = (SUM_W > MIN_LAT_W) ? SUM_W : MIN_LAT_W;
    localparam int SCMP_W  = ((SAMPLE_BITS > FIELD_SAMPLE_W) ? SAMPLE_BITS : FIELD_SAMPLE_W) + 1;
    localparam logic [LATENCY_BITS-1:0] LAT_MAX = '1;

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_SEARCH = 2'b10
    } top_state_t;

    top_state_t                     state_reg, state_next;
    logic [PERIOD_W-1:0]            period_reg;
    logic [THRESH_W-1:0]            thresh_reg;
    logic [MIN_LAT_W-1:0]           min_lat_reg;
    logic [MARGIN_W-1:0]            margin_reg;
    logic                           cal_reg, cal_next;
    logic                           wait_reg, wait_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [LATENCY_BITS-1:0]        offset_reg, offset_next;
    logic signed [SAMPLE_BITS-1:0]  peak_l_reg, peak_l_next, peak_r_reg, peak_r_next;
    logic [POS_W-1:0]               ppos_l_reg, ppos_l_next, ppos_r_reg, ppos_r_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [LATENCY_BITS-1:0]        lat_l_reg, lat_l_next, lat_r_reg, lat_r_next;
    logic                           out_valid_reg, out_valid_next;
    clc_out_t                       out_reg, out_next;

    logic                           in_acc;
    logic [PERIOD_W-1:0]            p_len;
    logic                           last;
    logic signed [SAMPLE_BITS-1:0]  s_l, s_r;
    logic signed [SCMP_W-1:0]       thr_ext;
    logic [SUM_W-1:0]               pl_sum, pr_sum, off_sum, lat_l_sum, lat_r_sum;
    logic [LATENCY_BITS-1:0]        pl_sat, pr_sat;
    logic [CNT_W-1:0]               count_inc;
    logic                           hit;
    logic                           fin_now;
    logic                           click, det;
    logic                           mem_wr_en;
    logic                           srch_start, srch_done;
    logic                           mem_rd_en;
    logic [IDX_W-1:0]               mem_rd_addr;
    logic [2*LATENCY_BITS-1:0]      mem_rd_data;
    logic [LATENCY_BITS-1:0]        best_l, best_r;

    assign in_ready  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign p_len = (period_reg < PERIOD_MIN) ? PERIOD_MIN :
                   (period_reg > PERIOD_MAX) ? PERIOD_MAX : period_reg;
    assign last  = PERIOD_W'(pos_reg) >= (p_len - PERIOD_W'(1));

    assign s_l     = $signed(SAMPLE_BITS'($unsigned(in_data.mic_left)));
    assign s_r     = $signed(SAMPLE_BITS'($unsigned(in_data.mic_right)));
    assign thr_ext = $signed(SCMP_W'(thresh_reg));

    assign pl_sum  = SUM_W'(ppos_l_next) + SUM_W'(offset_reg);
    assign pr_sum  = SUM_W'(ppos_r_next) + SUM_W'(offset_reg);
    assign pl_sat  = pl_sum[LATENCY_BITS] ? LAT_MAX : pl_sum[LATENCY_BITS-1:0];
    assign pr_sat  = pr_sum[LATENCY_BITS] ? LAT_MAX : pr_sum[LATENCY_BITS-1:0];
    assign off_sum = SUM_W'(offset_reg) + SUM_W'(p_len);

    assign hit = (SCMP_W'(peak_l_next) > thr_ext) && (SCMP_W'(peak_r_next) > thr_ext) &&
                 (CMP_W'(pl_sum) > CMP_W'(min_lat_reg)) &&
                 (CMP_W'(pr_sum) > CMP_W'(min_lat_reg));

    assign count_inc = count_reg + CNT_W'(1);

    assign lat_l_sum = SUM_W'(best_l) + SUM_W'(margin_reg);
    assign lat_r_sum = SUM_W'(best_r) + SUM_W'(margin_reg);

    always_comb
    begin
        state_next     = state_reg;
        cal_next       = cal_reg;
        wait_next      = wait_reg;
        pos_next       = pos_reg;
        offset_next    = offset_reg;
        peak_l_next    = peak_l_reg;
        peak_r_next    = peak_r_reg;
        ppos_l_next    = ppos_l_reg;
        ppos_r_next    = ppos_r_reg;
        count_next     = count_reg;
        lat_l_next     = lat_l_reg;
        lat_r_next     = lat_r_reg;
        click          = 1'b0;
        det            = 1'b0;
        fin_now        = 1'b0;
        mem_wr_en      = 1'b0;

        if (in_acc && in_data.cmd == CMD_TICK && cal_reg && wait_reg)
        begin
            if (pos_reg == '0 || s_l > peak_l_reg)
            begin
                peak_l_next = s_l;
                ppos_l_next = pos_reg;
            end
            if (pos_reg == '0 || s_r > peak_r_reg)
            begin
                peak_r_next = s_r;
                ppos_r_next = pos_reg;
            end
        end

        if (in_acc)
        begin
            unique case (in_data.cmd)
                CMD_START, CMD_ABORT:
                begin
                    cal_next    = (in_data.cmd == CMD_START);
                    wait_next   = 1'b0;
                    pos_next    = '0;
                    offset_next = '0;
                    count_next  = '0;
                end
                CMD_TICK:
                begin
                    if (cal_reg)
                    begin
                        if (!wait_reg)
                        begin
                            click = last;
                            if (last)
                            begin
                                wait_next   = 1'b1;
                                offset_next = '0;
                            end
                        end
                        else if (last)
                        begin
                            if (hit)
                            begin
                                det       = 1'b1;
                                wait_next = 1'b0;
                                if (count_reg < CNT_W'(MEASURES))
                                begin
                                    mem_wr_en  = 1'b1;
                                    count_next = count_inc;
                                end
                                if (count_inc >= CNT_W'(MEASURES))
                                begin
                                    fin_now    = 1'b1;
                                    cal_next   = 1'b0;
                                    count_next = '0;
                                    state_next = ST_SEARCH;
                                end
                            end
                            else
                            begin
                                offset_next = off_sum[LATENCY_BITS] ? LAT_MAX
                                                                    : off_sum[LATENCY_BITS-1:0];
                            end
                        end
                        pos_next = last ? '0 : pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (srch_done)
        begin
            lat_l_next = lat_l_sum[LATENCY_BITS] ? LAT_MAX : lat_l_sum[LATENCY_BITS-1:0];
            lat_r_next = lat_r_sum[LATENCY_BITS] ? LAT_MAX : lat_r_sum[LATENCY_BITS-1:0];
            state_next = ST_RUN;
        end
    end

    assign srch_start = fin_now;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (srch_done)
        begin
            out_valid_next          = 1'b1;
            out_next.click_out      = 1'b0;
            out_next.calibrating    = 1'b0;
            out_next.click_detected = 1'b1;
            out_next.finished       = 1'b1;
            out_next.latency_left   = FIELD_LAT_W'(lat_l_next);
            out_next.latency_right  = FIELD_LAT_W'(lat_r_next);
        end
        else if (in_acc && !fin_now)
        begin
            out_valid_next          = 1'b1;
            out_next.click_out      = click;
            out_next.calibrating    = cal_next;
            out_next.click_detected = det;
            out_next.finished       = 1'b0;
            out_next.latency_left   = FIELD_LAT_W'(lat_l_reg);
            out_next.latency_right  = FIELD_LAT_W'(lat_r_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            period_reg    <= PERIOD_RESET;
            thresh_reg    <= THRESH_RESET;
            min_lat_reg   <= MIN_LAT_RESET;
            margin_reg    <= MARGIN_RESET;
            cal_reg       <= 1'b0;
            wait_reg      <= 1'b0;
            pos_reg       <= '0;
            offset_reg    <= '0;
            peak_l_reg    <= '0;
            peak_r_reg    <= '0;
            ppos_l_reg    <= '0;
            ppos_r_reg    <= '0;
            count_reg     <= '0;
            lat_l_reg     <= LATENCY_BITS'(LATENCY_RESET);
            lat_r_reg     <= LATENCY_BITS'(LATENCY_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cal_reg       <= cal_next;
            wait_reg      <= wait_next;
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            peak_l_reg    <= peak_l_next;
            peak_r_reg    <= peak_r_next;
            ppos_l_reg    <= ppos_l_next;
            ppos_r_reg    <= ppos_r_next;
            count_reg     <= count_next;
            lat_l_reg     <= lat_l_next;
            lat_r_reg     <= lat_r_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PERIOD:  period_reg  <= cfg_data[PERIOD_W-1:0];
                    REG_THRESH:  thresh_reg  <= cfg_data[THRESH_W-1:0];
                    REG_MIN_LAT: min_lat_reg <= cfg_data[MIN_LAT_W-1:0];
                    REG_MARGIN:  margin_reg  <= cfg_data[MARGIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    clc_measure_mem #(
        .MEASURES     (MEASURES),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({pl_sat, pr_sat}),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    clc_mode_search #(
        .MEASURES     (MEASURES),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (srch_start),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .done       (srch_done),
        .best_left  (best_l),
        .best_right (best_r)
    );

    a_wait_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |-> cal_reg)
        else $error("waiting for a click outside calibration");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MEASURES))
        else $error("measure count past the store depth");

    a_finish_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && fin_now) |=> (state_reg == ST_SEARCH && !cal_reg && !out_valid_reg))
        else $error("last measure did not start the search");

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> (state_reg == ST_SEARCH))
        else $error("search result outside search state");

    a_finished_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.finished) |-> (!out_reg.calibrating && out_reg.click_detected))
        else $error("finished word inconsistent");

endmodule

`default_nettype wire

FILE: hdl/clc_measure_mem.sv
// measure store: one entry holds the left and right measure of one click
// synchronous memory, one write and one read port, read data registered; uses clc_pkg
`default_nettype none

module clc_measure_mem
    import clc_pkg::*;
#(
    parameter int MEASURES     = MEASURES_DEF,
    parameter int LATENCY_BITS = LATENCY_BITS_DEF,
    localparam int IDX_W       = (MEASURES > 1) ? $clog2(MEASURES) : 1
)
(
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_addr,
    input  wire logic [2*LATENCY_BITS-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [IDX_W-1:0]          rd_addr,
    output logic      [2*LATENCY_BITS-1:0] rd_data
);

    logic [2*LATENCY_BITS-1:0] mem [MEASURES];
    logic [2*LATENCY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/clc_mode_search.sv
// most-frequent search over the measure store, both channels side by side
// reads one entry a cycle through clc_measure_mem while scanning; uses clc_pkg
`default_nettype none

module clc_mode_search
    import clc_pkg::*;
#(
    parameter int MEASURES     = MEASURES_DEF,
    parameter int LATENCY_BITS = LATENCY_BITS_DEF,
    localparam int IDX_W       = (MEASURES > 1) ? $clog2(MEASURES) : 1,
    localparam int CNT_W       = $clog2(MEASURES + 1)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           rd_en,
    output logic      [IDX_W-1:0]          rd_addr,
    input  wire logic [2*LATENCY_BITS-1:0] rd_data,
    output logic                           done,
    output logic      [LATENCY_BITS-1:0]   best_left,
    output logic      [LATENCY_BITS-1:0]   best_right
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PIVOT  = 6'b000010,
        S_LATCH  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } srch_state_t;

    srch_state_t             st_reg, st_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [LATENCY_BITS-1:0] piv_l_reg, piv_l_next, piv_r_reg, piv_r_next;
    logic [CNT_W-1:0]        cnt_l_reg, cnt_l_next, cnt_r_reg, cnt_r_next;
    logic [LATENCY_BITS-1:0] best_l_reg, best_l_next, best_r_reg, best_r_next;
    logic [CNT_W-1:0]        bcnt_l_reg, bcnt_l_next, bcnt_r_reg, bcnt_r_next;
    logic [LATENCY_BITS-1:0] rd_l, rd_r;

    assign rd_l = rd_data[2*LATENCY_BITS-1:LATENCY_BITS];
    assign rd_r = rd_data[LATENCY_BITS-1:0];

    always_comb
    begin
        st_next     = st_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        piv_l_next  = piv_l_reg;
        piv_r_next  = piv_r_reg;
        cnt_l_next  = cnt_l_reg;
        cnt_r_next  = cnt_r_reg;
        best_l_next = best_l_reg;
        best_r_next = best_r_reg;
        bcnt_l_next = bcnt_l_reg;
        bcnt_r_next = bcnt_r_reg;
        rd_en       = 1'b0;
        rd_addr     = i_reg;
        done        = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next      = '0;
                    best_l_next = '0;
                    best_r_next = '0;
                    bcnt_l_next = '0;
                    bcnt_r_next = '0;
                    st_next     = S_PIVOT;
                end
            end
            S_PIVOT:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg;
                st_next = S_LATCH;
            end
            S_LATCH:
            begin
                piv_l_next = rd_l;
                piv_r_next = rd_r;
                rd_en      = 1'b1;
                rd_addr    = '0;
                j_next     = CNT_W'(1);
                cnt_l_next = '0;
                cnt_r_next = '0;
                st_next    = S_SCAN;
            end
            S_SCAN:
            begin
                // read data belongs to entry j - 1
                cnt_l_next = cnt_l_reg + CNT_W'(rd_l == piv_l_reg);
                cnt_r_next = cnt_r_reg + CNT_W'(rd_r == piv_r_reg);
                if (j_reg == CNT_W'(MEASURES))
                begin
                    st_next = S_UPDATE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg[IDX_W-1:0];
                    j_next  = j_reg + CNT_W'(1);
                end
            end
            S_UPDATE:
            begin
                if ((cnt_l_reg > bcnt_l_reg) ||
                    (cnt_l_reg == bcnt_l_reg && piv_l_reg < best_l_reg))
                begin
                    bcnt_l_next = cnt_l_reg;
                    best_l_next = piv_l_reg;
                end
                if ((cnt_r_reg > bcnt_r_reg) ||
                    (cnt_r_reg == bcnt_r_reg && piv_r_reg < best_r_reg))
                begin
                    bcnt_r_next = cnt_r_reg;
                    best_r_next = piv_r_reg;
                end
                if (i_reg == IDX_W'(MEASURES - 1))
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    i_next  = i_reg + IDX_W'(1);
                    st_next = S_PIVOT;
                end
            end
            S_DONE:
            begin
                done    = 1'b1;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        piv_l_reg  <= piv_l_next;
        piv_r_reg  <= piv_r_next;
        cnt_l_reg  <= cnt_l_next;
        cnt_r_reg  <= cnt_r_next;
        best_l_reg <= best_l_next;
        best_r_reg <= best_r_next;
        bcnt_l_reg <= bcnt_l_next;
        bcnt_r_reg <= bcnt_r_next;
    end

    assign best_left  = best_l_reg;
    assign best_right = best_r_reg;

    a_done_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE) |-> $past(st_reg == S_UPDATE))
        else $error("search done without a final update");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SCAN) |-> (j_reg != '0 && j_reg <= CNT_W'(MEASURES)))
        else $error("scan index out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_UPDATE) |-> (cnt_l_reg != '0 && cnt_r_reg != '0))
        else $error("pivot not counted against itself");

endmodule

`default_nettype wire

FILE: test/clc_tb_pkg.sv
// scoreboard of the click latency calibrator testbench: predicts every output word
// from the accepted input words and register writes, and checks arriving words
// depends on clc_pkg
package clc_tb_pkg;

    import clc_pkg::*;

    localparam int unsigned LAT_MAX = (1 << LATENCY_BITS_DEF) - 1;

    class clc_scoreboard;

        logic [PERIOD_W-1:0]  period_len;
        logic [THRESH_W-1:0]  threshold;
        logic [MIN_LAT_W-1:0] min_lat;
        logic [MARGIN_W-1:0]  margin;

        bit                               cal_mode;
        bit                               awaiting_click;
        logic [POS_W-1:0]                 sample_pos;
        int unsigned                      recv_offset;
        logic signed [FIELD_SAMPLE_W-1:0] peak_val [2];
        logic [POS_W-1:0]                 peak_pos [2];
        int unsigned                      n_measures;
        int unsigned                      measure_store [2][MEASURES_DEF];
        int unsigned                      latency [2];

        clc_out_t    due_out_words [$];
        int unsigned errors;
        int unsigned words_seen;

        function new();
            period_len     = PERIOD_RESET;
            threshold      = THRESH_RESET;
            min_lat        = MIN_LAT_RESET;
            margin         = MARGIN_RESET;
            cal_mode       = 1'b0;
            peak_val[0]    = '0;
            peak_val[1]    = '0;
            peak_pos[0]    = '0;
            peak_pos[1]    = '0;
            latency[0]     = LATENCY_RESET;
            latency[1]     = LATENCY_RESET;
            errors         = 0;
            words_seen     = 0;
            clear_run();
        endfunction

        function void clear_run();
            awaiting_click = 1'b0;
            sample_pos     = '0;
            recv_offset    = 0;
            n_measures     = 0;
        endfunction

        function int unsigned eff_period();
            int unsigned p;
            p = period_len;
            if (p < PERIOD_MIN)
                p = PERIOD_MIN;
            if (p > PERIOD_MAX)
                p = PERIOD_MAX;
            return p;
        endfunction

        function int unsigned sat_lat(longint unsigned v);
            return (v > LAT_MAX) ? LAT_MAX : int'(v);
        endfunction

        // smallest value among the most frequent measures of one channel
        function int unsigned most_common(int ch);
            int unsigned best;
            int unsigned best_cnt;
            int unsigned c;
            int i;
            int j;
            best = 0;
            best_cnt = 0;
            for (i = 0; i < n_measures; i++)
            begin
                c = 0;
                for (j = 0; j < n_measures; j++)
                    if (measure_store[ch][j] == measure_store[ch][i])
                        c++;
                if (c > best_cnt || (c == best_cnt && measure_store[ch][i] < best))
                begin
                    best_cnt = c;
                    best = measure_store[ch][i];
                end
            end
            return best;
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PERIOD:  period_len = data[PERIOD_W-1:0];
                REG_THRESH:  threshold  = data[THRESH_W-1:0];
                REG_MIN_LAT: min_lat    = data[MIN_LAT_W-1:0];
                REG_MARGIN:  margin     = data[MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_in_word(clc_in_t w);
            clc_out_t                         r;
            int unsigned                      p;
            int unsigned                      pos_sum [2];
            bit                               at_end;
            bit                               hit;
            logic signed [FIELD_SAMPLE_W-1:0] s [2];
            int                               k;
            r = '0;
            s[0] = w.mic_left;
            s[1] = w.mic_right;
            if (w.cmd == CMD_START)
            begin
                cal_mode = 1'b1;
                clear_run();
            end
            else if (w.cmd == CMD_ABORT)
            begin
                cal_mode = 1'b0;
                clear_run();
            end
            else if (w.cmd == CMD_TICK && cal_mode)
            begin
                p = eff_period();
                at_end = (sample_pos >= p - 1);
                if (!awaiting_click)
                begin
                    r.click_out = at_end;
                    if (at_end)
                    begin
                        awaiting_click = 1'b1;
                        recv_offset = 0;
                    end
                end
                else
                begin
                    for (k = 0; k < 2; k++)
                        if (sample_pos == 0 || s[k] > peak_val[k])
                        begin
                            peak_val[k] = s[k];
                            peak_pos[k] = sample_pos;
                        end
                    if (at_end)
                    begin
                        pos_sum[0] = peak_pos[0] + recv_offset;
                        pos_sum[1] = peak_pos[1] + recv_offset;
                        hit = int'(peak_val[0]) > int'(threshold)
                            && int'(peak_val[1]) > int'(threshold)
                            && pos_sum[0] > min_lat && pos_sum[1] > min_lat;
                        if (hit)
                        begin
                            r.click_detected = 1'b1;
                            if (n_measures < MEASURES_DEF)
                            begin
                                measure_store[0][n_measures] = sat_lat(pos_sum[0]);
                                measure_store[1][n_measures] = sat_lat(pos_sum[1]);
                                n_measures++;
                            end
                            if (n_measures >= MEASURES_DEF)
                            begin
                                latency[0] = sat_lat(longint'(most_common(0)) + margin);
                                latency[1] = sat_lat(longint'(most_common(1)) + margin);
                                r.finished = 1'b1;
                                cal_mode = 1'b0;
                                n_measures = 0;
                            end
                            awaiting_click = 1'b0;
                        end
                        else
                            recv_offset = sat_lat(longint'(recv_offset) + p);
                    end
                end
                sample_pos = at_end ? '0 : sample_pos + 1'b1;
            end
            r.calibrating   = cal_mode;
            r.latency_left  = FIELD_LAT_W'(latency[0]);
            r.latency_right = FIELD_LAT_W'(latency[1]);
            due_out_words.push_back(r);
        endfunction

        function int unsigned pending();
            return due_out_words.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("output word %0d: %s got %0h expected %0h", words_seen, what, got, want);
        endtask

        task check_out_word(clc_out_t got);
            clc_out_t want;
            words_seen++;
            if (due_out_words.size() == 0)
                report("word with nothing expected", got[31:0], '0);
            else
            begin
                want = due_out_words.pop_front();
                if (got.click_out !== want.click_out)
                    report("click_out", got.click_out, want.click_out);
                if (got.calibrating !== want.calibrating)
                    report("calibrating", got.calibrating, want.calibrating);
                if (got.click_detected !== want.click_detected)
                    report("click_detected", got.click_detected, want.click_detected);
                if (got.finished !== want.finished)
                    report("finished", got.finished, want.finished);
                if (got.latency_left !== want.latency_left)
                    report("latency_left", got.latency_left, want.latency_left);
                if (got.latency_right !== want.latency_right)
                    report("latency_right", got.latency_right, want.latency_right);
            end
        endtask

    endclass

endpackage

FILE: test/tb_top.sv
// top of the click latency calibrator testbench: clock, reset, drivers and checks
// directed words, then random calibration runs with idling and backpressure
// depends on clc_pkg, clc_tb_pkg and click_latency_calibrator
module tb_top
    import clc_pkg::*, clc_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);
    localparam int unsigned TOTAL_ITEMS    = 1925;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int S_MIN = -32768;
    localparam int S_MAX = 32767;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    clc_in_t in_data;
    logic out_valid;
    logic out_ready;
    clc_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    clc_scoreboard sb;
    int unsigned items_sent;
    bit tx_free;
    bit rx_free;
    bit tx_high;
    bit rx_hold_req;

    // plan of the current receive period
    bit plan_hit [2];
    int unsigned plan_pos [2];
    int plan_val [2];
    int unsigned base_pos [2];

    always #4 clk = ~clk;

    click_latency_calibrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_sample(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic clc_in_t word_of(logic [CMD_W-1:0] c, int l, int r);
        clc_in_t w;
        w.cmd = c;
        w.mic_left = FIELD_SAMPLE_W'(l);
        w.mic_right = FIELD_SAMPLE_W'(r);
        return w;
    endfunction

    // tick word shaped so that most receive periods carry a clean click
    function automatic clc_in_t make_tick();
        int unsigned p;
        int thr;
        int k;
        int v [2];
        p = sb.eff_period();
        thr = int'(sb.threshold);
        if (sb.cal_mode && sb.awaiting_click)
        begin
            if (sb.sample_pos == 0)
                for (k = 0; k < 2; k++)
                begin
                    plan_hit[k] = ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 9) < 7 && base_pos[k] < p)
                        plan_pos[k] = base_pos[k];
                    else
                        plan_pos[k] = $urandom_range(p - 1);
                    plan_val[k] = (thr >= S_MAX) ? S_MAX : rand_sample(thr + 1, S_MAX);
                end
            for (k = 0; k < 2; k++)
            begin
                if (plan_hit[k] && sb.sample_pos == plan_pos[k])
                    v[k] = plan_val[k];
                else if ($urandom_range(0, 49) == 0)
                    v[k] = rand_sample(S_MIN, S_MAX);
                else if (plan_hit[k])
                    v[k] = rand_sample(S_MIN, plan_val[k] - 1);
                else
                    v[k] = rand_sample(S_MIN, thr);
            end
        end
        else
        begin
            v[0] = rand_sample(S_MIN, S_MAX);
            v[1] = rand_sample(S_MIN, S_MAX);
        end
        return word_of(CMD_TICK, v[0], v[1]);
    endfunction

    task automatic put_word(input clc_in_t w);
        int unsigned g;
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_in_word(w);
        items_sent++;
        tx_high = 1'b1;
        g = tx_free ? 0 : idle_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            tx_high = 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (tx_high)
        begin
            in_valid <= 1'b0;
            tx_high = 1'b0;
        end
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(v);
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.note_config(idx, CFG_DATA_W'(v));
    endtask

    task automatic set_config(input int unsigned plen, input int unsigned thr,
                              input int unsigned mlat, input int unsigned marg);
        write_reg(REG_PERIOD, plen);
        write_reg(REG_THRESH, thr);
        write_reg(REG_MIN_LAT, mlat);
        write_reg(REG_MARGIN, marg);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : rx_side
        int unsigned gap;
        gap = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (gap != 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_free)
                    gap = idle_len();
            end
        end
    end

    initial
    begin : out_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
                sb.check_out_word(out_data);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
                || (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned r;
        int unsigned plen;
        int unsigned ep;
        int unsigned thr;
        int unsigned mlat;
        int unsigned marg;
        int unsigned n;
        int unsigned sess;
        sb = new();
        items_sent = 0;
        tx_free = 1'b0;
        rx_free = 1'b0;
        tx_high = 1'b0;
        rx_hold_req = 1'b0;
        base_pos[0] = 0;
        base_pos[1] = 0;
        plan_hit[0] = 1'b0;
        plan_hit[1] = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // outside calibration: ticks, unused code and abort change nothing
        put_word(word_of(CMD_TICK, S_MIN, S_MAX));
        put_word(word_of(CMD_UNUSED, S_MAX, S_MIN));
        put_word(word_of(CMD_ABORT, 0, 0));
        drain();

        // period below range taken as two, lowest threshold and min latency
        set_config(0, 0, 0, 1023);
        put_word(word_of(CMD_START, -1, -1));
        put_word(word_of(CMD_TICK, -1, -1));
        put_word(word_of(CMD_TICK, 0, 0));
        put_word(word_of(CMD_TICK, 100, -5));
        put_word(word_of(CMD_TICK, 200, S_MAX));
        put_word(word_of(CMD_UNUSED, 7, 7));
        put_word(word_of(CMD_TICK, 0, 0));
        // start while calibrating drops the run
        put_word(word_of(CMD_START, 3, 3));
        put_word(word_of(CMD_TICK, 0, 0));
        put_word(word_of(CMD_TICK, 0, 0));
        // peak at position zero with no offset is not above min latency
        put_word(word_of(CMD_TICK, 1, 1));
        put_word(word_of(CMD_TICK, 0, 0));
        put_word(word_of(CMD_TICK, 0, 0));
        put_word(word_of(CMD_TICK, 5, 5));
        put_word(word_of(CMD_ABORT, 0, 0));
        drain();

        // period above range, then shortened in the middle of a period
        set_config(16383, 32767, 1048575, 0);
        put_word(word_of(CMD_START, 0, 0));
        repeat (3) put_word(word_of(CMD_TICK, S_MAX, S_MAX));
        drain();
        set_config(1, 32767, 1048575, 0);
        put_word(word_of(CMD_TICK, 0, 0));
        put_word(word_of(CMD_TICK, S_MAX, S_MAX));
        put_word(word_of(CMD_TICK, S_MAX, S_MAX));

        sess = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            drain();
            r = $urandom_range(0, 19);
            plen = (r < 1) ? $urandom_range(0, 1) : (r < 3) ? $urandom_range(7, 24)
                 : $urandom_range(2, 4);
            ep = (plen < 2) ? 2 : plen;
            r = $urandom_range(0, 9);
            thr = (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(1000, 30000);
            r = $urandom_range(0, 19);
            mlat = (r == 0) ? 1048575 : (r < 5) ? 0 : $urandom_range(0, 2 * ep);
            r = $urandom_range(0, 4);
            marg = (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 1023);
            tx_free = ($urandom_range(0, 3) == 0) || (sess == 1);
            rx_free = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                set_config($urandom_range(0, 1) ? 8192 : $urandom_range(8193, 16383),
                           thr, mlat, marg);
                put_word(word_of(CMD_START, rand_sample(S_MIN, S_MAX),
                                 rand_sample(S_MIN, S_MAX)));
                repeat ($urandom_range(3, 40)) put_word(make_tick());
                drain();
            end
            set_config(plen, thr, mlat, marg);
            base_pos[0] = $urandom_range(ep - 1);
            base_pos[1] = $urandom_range(ep - 1);
            repeat ($urandom_range(0, 2)) put_word(make_tick());
            if (!sb.cal_mode)
                put_word(word_of(CMD_START, rand_sample(S_MIN, S_MAX),
                                 rand_sample(S_MIN, S_MAX)));
            // long receiver hold-off while words keep coming
            if (sess == 1)
                rx_hold_req = 1'b1;
            n = 0;
            while (sb.cal_mode && n < 300 && items_sent < TOTAL_ITEMS)
            begin
                r = $urandom_range(0, 999);
                if (r < 3)
                    put_word(word_of(CMD_ABORT, rand_sample(S_MIN, S_MAX),
                                     rand_sample(S_MIN, S_MAX)));
                else if (r < 6)
                    put_word(word_of(CMD_START, rand_sample(S_MIN, S_MAX),
                                     rand_sample(S_MIN, S_MAX)));
                else if (r < 10)
                    put_word(word_of(CMD_UNUSED, rand_sample(S_MIN, S_MAX),
                                     rand_sample(S_MIN, S_MAX)));
                else
                    put_word(make_tick());
                n++;
                if (!sb.cal_mode && r < 3 && $urandom_range(0, 1) == 1)
                    put_word(word_of(CMD_START, 0, 0));
            end
            sess++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
